// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, suspended while reset is low.
`define MTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent check on the rising clock edge that also runs during reset.
`define MTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/mts_pkg.sv -----
`default_nettype none

package mts_pkg;

  // Field widths.
  localparam int unsigned TickW   = 32;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned DimW    = 13;
  localparam int unsigned BlockW  = 8;
  localparam int unsigned RatioW  = 8;
  localparam int unsigned OfsW    = 9;
  localparam int unsigned RelW    = 14;
  localparam int unsigned ProdW   = TickW + BlockW;

  // Limits applied to the configuration registers.
  localparam int unsigned MaxDim      = 4096;
  localparam int unsigned BlockLimit  = 255;
  localparam int unsigned MinBlock    = 2;
  localparam int unsigned MinDuration = 2;
  localparam int unsigned RatioMax    = 255;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegDuration = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegWidth    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegHeight   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegMaxBlock = CfgIdxW'(3);

  localparam logic [TickW-1:0]  DurationReset = TickW'(1000);
  localparam logic [DimW-1:0]   WidthReset    = DimW'(640);
  localparam logic [DimW-1:0]   HeightReset   = DimW'(480);
  localparam logic [BlockW-1:0] MaxBlockReset = BlockW'(30);

  // Item kinds carried in tuser.
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Stream payload widths.
  localparam int unsigned InDataW  = TickW + 2 * CoordW;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutPadW  = OutDataW - (2 * CoordW + BlockW + RatioW + 2 * OfsW + 1);

  // Shared divider: the quotient of every division fits in DivQW bits.
  localparam int unsigned DivQW   = 13;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned DivNumW = DivDenW + DivQW - 1;
  localparam int unsigned DivCntW = $clog2(DivQW + 1);

  typedef enum logic [2:0] {
    DIV_BLOCK,
    DIV_RATIO,
    DIV_GRID_X,
    DIV_GRID_Y,
    DIV_SAMPLE_X,
    DIV_SAMPLE_Y
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     elapsed;
    logic     product;
    logic     div_start;
    logic     div_take;
    div_sel_e div_sel;
    logic     out_load;
  } mts_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mts_divider.sv -----
`default_nettype none

module mts_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mts_pkg::DivNumW-1:0]  num_i,
  input  logic [mts_pkg::DivDenW-1:0]  den_i,
  output logic [mts_pkg::DivQW-1:0]    quot_o,
  output logic [mts_pkg::DivDenW-1:0]  rem_o,
  output logic                         done_o
);
  import mts_pkg::*;

  logic [DivNumW-1:0] rem_q;
  logic [DivNumW-1:0] dvs_q;
  logic [DivQW-1:0]   quot_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic               fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign fits = (rem_q >= dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivQW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dvs_q  <= {den_i, {(DivQW - 1){1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dvs_q;
      end
      quot_q <= {quot_q[DivQW-2:0], fits};
      dvs_q  <= dvs_q >> 1;
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q[DivDenW-1:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/mts_datapath.sv -----
`default_nettype none

module mts_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mts_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [mts_pkg::InDataW-1:0]   in_data_i,
  input  logic                          in_kind_i,
  input  mts_pkg::mts_cmd_t             cmd_i,
  output logic                          div_done_o,
  output logic [mts_pkg::OutDataW-1:0]  out_data_o
);
  import mts_pkg::*;

  function automatic logic [DimW-1:0] dim_used(logic [DimW-1:0] v);
    logic [DimW-1:0] d;
    if (v == '0) begin
      d = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      d = DimW'(MaxDim);
    end else begin
      d = v;
    end
    dim_used = d;
  endfunction

  // Distance of a pixel from the grid origin; never below zero.
  function automatic logic signed [RelW-1:0] rel_of(logic [CoordW-1:0] p,
                                                   logic signed [OfsW-1:0] ofs);
    logic signed [RelW-1:0] r;
    r = $signed(RelW'(p)) - RelW'(ofs);
    if (r < 0) begin
      r = '0;
    end
    rel_of = r;
  endfunction

  // Block centre of a pixel, clamped to the image.
  function automatic logic [CoordW-1:0] sample_pos(logic signed [RelW-1:0] rel,
                                                   logic [BlockW-1:0] rem,
                                                   logic signed [OfsW-1:0] ofs,
                                                   logic [BlockW-1:0] bs,
                                                   logic [DimW-1:0] dim);
    logic signed [RelW-1:0] c;
    logic signed [RelW-1:0] dim_s;
    logic [CoordW-1:0]      s;
    c = rel - $signed(RelW'(rem)) + RelW'(ofs) + $signed(RelW'(bs >> 1));
    dim_s = $signed(RelW'(dim));
    if (c < 0) begin
      s = '0;
    end else if (c >= dim_s) begin
      s = CoordW'(dim - DimW'(1));
    end else begin
      s = CoordW'(c);
    end
    sample_pos = s;
  endfunction

  // Grid offset that centres the middle block. The half difference rounds
  // toward zero, so a negative difference is bumped by one before the shift.
  function automatic logic signed [OfsW-1:0] grid_pos(logic [DimW-1:0] dim,
                                                     logic [BlockW-1:0] bs,
                                                     logic [BlockW-1:0] rem);
    logic signed [RelW-1:0] snapped;
    logic signed [RelW-1:0] diff;
    logic signed [RelW-1:0] half;
    logic signed [RelW-1:0] o;
    snapped = $signed(RelW'(dim >> 1)) - $signed(RelW'(rem));
    diff    = $signed(RelW'(dim)) - $signed(RelW'(bs));
    half    = (diff - (diff >>> (RelW - 1))) >>> 1;
    o       = half - snapped;
    if (o > 0) begin
      o = o - $signed(RelW'(bs));
    end
    grid_pos = OfsW'(o);
  endfunction

  function automatic logic [OutDataW-1:0] pack_result(logic [CoordW-1:0] sx,
                                                      logic [CoordW-1:0] sy,
                                                      logic [BlockW-1:0] bs,
                                                      logic [RatioW-1:0] ratio,
                                                      logic signed [OfsW-1:0] ox,
                                                      logic signed [OfsW-1:0] oy);
    pack_result = {OutPadW'(0), (ratio == RatioW'(RatioMax)), oy, ox, ratio, bs, sy, sx};
  endfunction

  // Configuration and transition state.
  logic [TickW-1:0]        duration_q;
  logic [DimW-1:0]         width_q;
  logic [DimW-1:0]         height_q;
  logic [BlockW-1:0]       max_block_q;
  logic                    first_pending_q;
  logic [TickW-1:0]        start_tick_q;
  logic [BlockW-1:0]       cur_block_q;
  logic [RatioW-1:0]       cur_ratio_q;
  logic signed [OfsW-1:0]  ofs_x_q;
  logic signed [OfsW-1:0]  ofs_y_q;

  // Item and working registers.
  logic                    kind_q;
  logic [TickW-1:0]        tick_q;
  logic [CoordW-1:0]       px_q;
  logic [CoordW-1:0]       py_q;
  logic [TickW-1:0]        t_q;
  logic [TickW-1:0]        cap_q;
  logic [ProdW-1:0]        prod_bs_q;
  logic [ProdW-1:0]        prod_r_q;
  logic [BlockW-1:0]       new_block_q;
  logic [RatioW-1:0]       new_ratio_q;
  logic signed [OfsW-1:0]  new_ofs_x_q;
  logic signed [OfsW-1:0]  new_ofs_y_q;
  logic [CoordW-1:0]       sx_q;
  logic [CoordW-1:0]       sy_q;
  logic [OutDataW-1:0]     out_data_q;

  // Combinational terms.
  logic [DimW-1:0]         dim_w;
  logic [DimW-1:0]         dim_h;
  logic [TickW-1:0]        dur;
  logic [TickW-1:0]        halft;
  logic [BlockW-1:0]       mb;
  logic [TickW-1:0]        start_eff;
  logic [TickW-1:0]        el;
  logic [TickW-1:0]        t_d;
  logic [TickW-1:0]        cap_d;
  logic signed [RelW-1:0]  rel_x;
  logic signed [RelW-1:0]  rel_y;
  logic [DivQW:0]          bs_full;
  logic [BlockW-1:0]       block_d;
  logic [RatioW-1:0]       ratio_d;
  logic [BlockW-1:0]       rem_b;
  logic [DivNumW-1:0]      div_num;
  logic [DivDenW-1:0]      div_den;
  logic [DivQW-1:0]        div_quot;
  logic [DivDenW-1:0]      div_rem;

  always_comb begin
    dim_w = dim_used(width_q);
    dim_h = dim_used(height_q);
    dur   = (duration_q < TickW'(MinDuration)) ? TickW'(MinDuration) : duration_q;
    halft = dur >> 1;
    if (max_block_q < BlockW'(MinBlock)) begin
      mb = BlockW'(MinBlock);
    end else if (max_block_q > BlockW'(BlockLimit)) begin
      mb = BlockW'(BlockLimit);
    end else begin
      mb = max_block_q;
    end
    // The first tick after reset becomes the start of the transition.
    start_eff = first_pending_q ? tick_q : start_tick_q;
    el        = tick_q - start_eff;
    cap_d     = (el > dur) ? dur : el;
    if (el >= halft) begin
      t_d = (el > dur) ? '0 : (dur - el);
    end else begin
      t_d = el;
    end
    rel_x   = rel_of(px_q, ofs_x_q);
    rel_y   = rel_of(py_q, ofs_y_q);
    bs_full = {1'b0, div_quot} + (DivQW + 1)'(MinBlock);
    block_d = (bs_full > (DivQW + 1)'(mb)) ? mb : BlockW'(bs_full);
    ratio_d = (div_quot > DivQW'(RatioMax)) ? RatioW'(RatioMax) : RatioW'(div_quot);
    rem_b   = BlockW'(div_rem);
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_BLOCK: begin
        div_num = DivNumW'(prod_bs_q);
        div_den = halft;
      end
      DIV_RATIO: begin
        div_num = DivNumW'(prod_r_q);
        div_den = dur;
      end
      DIV_GRID_X: begin
        div_num = DivNumW'(dim_w >> 1);
        div_den = DivDenW'(new_block_q);
      end
      DIV_GRID_Y: begin
        div_num = DivNumW'(dim_h >> 1);
        div_den = DivDenW'(new_block_q);
      end
      DIV_SAMPLE_X: begin
        div_num = DivNumW'($unsigned(rel_x));
        div_den = DivDenW'(cur_block_q);
      end
      DIV_SAMPLE_Y: begin
        div_num = DivNumW'($unsigned(rel_y));
        div_den = DivDenW'(cur_block_q);
      end
      default: begin
        div_num = '0;
        div_den = DivDenW'(1);
      end
    endcase
  end

  mts_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .rem_o   (div_rem),
    .done_o  (div_done_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q      <= DurationReset;
      width_q         <= WidthReset;
      height_q        <= HeightReset;
      max_block_q     <= MaxBlockReset;
      first_pending_q <= 1'b1;
      start_tick_q    <= '0;
      cur_block_q     <= BlockW'(MinBlock);
      cur_ratio_q     <= '0;
      ofs_x_q         <= '0;
      ofs_y_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDuration: duration_q  <= TickW'(cfg_data_i);
          RegWidth:    width_q     <= DimW'(cfg_data_i);
          RegHeight:   height_q    <= DimW'(cfg_data_i);
          RegMaxBlock: max_block_q <= BlockW'(cfg_data_i);
          default: ;
        endcase
      end
      if (cmd_i.elapsed) begin
        first_pending_q <= 1'b0;
        start_tick_q    <= start_eff;
      end
      if (cmd_i.out_load && (kind_q == CmdTick)) begin
        cur_block_q <= new_block_q;
        cur_ratio_q <= new_ratio_q;
        ofs_x_q     <= new_ofs_x_q;
        ofs_y_q     <= new_ofs_y_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      tick_q <= in_data_i[TickW-1:0];
      px_q   <= in_data_i[TickW +: CoordW];
      py_q   <= in_data_i[TickW + CoordW +: CoordW];
    end
    if (cmd_i.elapsed) begin
      t_q   <= t_d;
      cap_q <= cap_d;
    end
    if (cmd_i.product) begin
      prod_bs_q <= ProdW'(mb - BlockW'(MinBlock)) * ProdW'(t_q);
      prod_r_q  <= ProdW'(cap_q) * ProdW'(RatioMax);
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_BLOCK:    new_block_q <= block_d;
        DIV_RATIO:    new_ratio_q <= ratio_d;
        DIV_GRID_X:   new_ofs_x_q <= grid_pos(dim_w, new_block_q, rem_b);
        DIV_GRID_Y:   new_ofs_y_q <= grid_pos(dim_h, new_block_q, rem_b);
        DIV_SAMPLE_X: sx_q <= sample_pos(rel_x, rem_b, ofs_x_q, cur_block_q, dim_w);
        DIV_SAMPLE_Y: sy_q <= sample_pos(rel_y, rem_b, ofs_y_q, cur_block_q, dim_h);
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      if (kind_q == CmdTick) begin
        out_data_q <= pack_result('0, '0, new_block_q, new_ratio_q, new_ofs_x_q,
                                  new_ofs_y_q);
      end else begin
        out_data_q <= pack_result(sx_q, sy_q, cur_block_q, cur_ratio_q, ofs_x_q, ofs_y_q);
      end
    end
  end

  assign out_data_o = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/mts_ctrl.sv -----
`default_nettype none

module mts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               in_kind_i,
  input  logic               div_done_i,
  input  logic               m_tready_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  output mts_pkg::mts_cmd_t  cmd_o
);
  import mts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_PRODUCT,
    ST_BLOCK_GO,
    ST_BLOCK_WAIT,
    ST_RATIO_GO,
    ST_RATIO_WAIT,
    ST_GX_GO,
    ST_GX_WAIT,
    ST_GY_GO,
    ST_GY_WAIT,
    ST_SX_GO,
    ST_SX_WAIT,
    ST_SY_GO,
    ST_SY_WAIT,
    ST_FINISH
  } state_e;

  state_e   state_q;
  state_e   state_d;
  logic     s_tready_q;
  logic     m_tvalid_q;
  mts_cmd_t cmd;

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    cmd.div_sel = DIV_BLOCK;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i && s_tready_q) begin
          cmd.load = 1'b1;
          state_d  = (in_kind_i == CmdQuery) ? ST_SX_GO : ST_ELAPSED;
        end
      end
      ST_ELAPSED: begin
        cmd.elapsed = 1'b1;
        state_d     = ST_PRODUCT;
      end
      ST_PRODUCT: begin
        cmd.product = 1'b1;
        state_d     = ST_BLOCK_GO;
      end
      ST_BLOCK_GO: begin
        cmd.div_start = 1'b1;
        state_d       = ST_BLOCK_WAIT;
      end
      ST_BLOCK_WAIT: begin
        if (div_done_i) begin
          cmd.div_take = 1'b1;
          state_d      = ST_RATIO_GO;
        end
      end
      ST_RATIO_GO: begin
        cmd.div_sel   = DIV_RATIO;
        cmd.div_start = 1'b1;
        state_d       = ST_RATIO_WAIT;
      end
      ST_RATIO_WAIT: begin
        cmd.div_sel = DIV_RATIO;
        if (div_done_i) begin
          cmd.div_take = 1'b1;
          state_d      = ST_GX_GO;
        end
      end
      ST_GX_GO: begin
        cmd.div_sel   = DIV_GRID_X;
        cmd.div_start = 1'b1;
        state_d       = ST_GX_WAIT;
      end
      ST_GX_WAIT: begin
        cmd.div_sel = DIV_GRID_X;
        if (div_done_i) begin
          cmd.div_take = 1'b1;
          state_d      = ST_GY_GO;
        end
      end
      ST_GY_GO: begin
        cmd.div_sel   = DIV_GRID_Y;
        cmd.div_start = 1'b1;
        state_d       = ST_GY_WAIT;
      end
      ST_GY_WAIT: begin
        cmd.div_sel = DIV_GRID_Y;
        if (div_done_i) begin
          cmd.div_take = 1'b1;
          state_d      = ST_FINISH;
        end
      end
      ST_SX_GO: begin
        cmd.div_sel   = DIV_SAMPLE_X;
        cmd.div_start = 1'b1;
        state_d       = ST_SX_WAIT;
      end
      ST_SX_WAIT: begin
        cmd.div_sel = DIV_SAMPLE_X;
        if (div_done_i) begin
          cmd.div_take = 1'b1;
          state_d      = ST_SY_GO;
        end
      end
      ST_SY_GO: begin
        cmd.div_sel   = DIV_SAMPLE_Y;
        cmd.div_start = 1'b1;
        state_d       = ST_SY_WAIT;
      end
      ST_SY_WAIT: begin
        cmd.div_sel = DIV_SAMPLE_Y;
        if (div_done_i) begin
          cmd.div_take = 1'b1;
          state_d      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result register may be refilled once its transaction is done.
        if (!m_tvalid_q || m_tready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s_tready_q <= 1'b1;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s_tready_q <= (state_d == ST_IDLE);
      if (cmd.out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign s_tready_o = s_tready_q;
  assign m_tvalid_o = m_tvalid_q;
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

// ----- rtl/mosaic_transition_sampler_unit.sv -----
// Mosaic transition sampler.
// Input stream: s_axis_tuser selects the transaction kind (0 frame tick,
// 1 pixel query); s_axis_tdata carries the tick count and the pixel position.
// A frame tick recomputes the block edge, the blend ratio and the grid
// offsets; a pixel query returns the clamped block centre to sample.
// Every input transaction yields exactly one output transaction.
// One item is in work at a time. All divisions run on the one shared divider:
// two per query and four per frame tick.
// The result sits in an output register, so the next item is accepted while
// a finished result still waits. If the receiver stalls, the block holds the
// next result internally until the output register frees up.
// Reset loads the default configuration, clears the output valid and arms
// the start tick to be taken from the next frame tick.
// Configuration writes are taken whenever cfg_we_i is high.
`default_nettype none

module mosaic_transition_sampler_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mts_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: tick_now[31:0], pixel_x[43:32], pixel_y[55:44]
  input  logic [mts_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: command
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: sample_x[11:0], sample_y[23:12], block_edge[31:24],
  // mix_ratio[39:32], grid_ofs_x[48:40], grid_ofs_y[57:49], finished[58]
  output logic [mts_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mts_pkg::*;

  mts_cmd_t cmd;
  logic     div_done;

  mts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .div_done_i (div_done),
    .m_tready_i (m_axis_tready),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  mts_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_kind_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .div_done_o (div_done),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/mts_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module mts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mts_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mts_pkg::*;

  logic                   in_fire;
  logic [BlockW-1:0]      block_edge;
  logic [RatioW-1:0]      mix_ratio;
  logic [OfsW-1:0]        grid_ofs_x;
  logic [OfsW-1:0]        grid_ofs_y;
  logic                   finished;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign block_edge = m_axis_tdata[31:24];
  assign mix_ratio  = m_axis_tdata[39:32];
  assign grid_ofs_x = m_axis_tdata[48:40];
  assign grid_ofs_y = m_axis_tdata[57:49];
  assign finished   = m_axis_tdata[58];

  // Only one item is worked on at a time.
  `MTS_ASSERT(a_one_item, clk_i, rst_ni, in_fire |=> !s_axis_tready, "input taken while busy")

  // A result is never presented straight after its input is taken; it waits on the divisions.
  `MTS_ASSERT(a_no_quick_result, clk_i, rst_ni, in_fire |=> !$rose(m_axis_tvalid), "result too early")

  `MTS_ASSERT(a_finished_flag, clk_i, rst_ni, m_axis_tvalid |-> (finished == (mix_ratio == 8'hFF)), "finished flag disagrees with ratio")

  // Block edge never drops below two and the grid offsets are never positive.
  `MTS_ASSERT(a_result_range, clk_i, rst_ni, m_axis_tvalid |-> ((block_edge >= 8'd2) && (grid_ofs_x[8] || (grid_ofs_x == 9'd0)) && (grid_ofs_y[8] || (grid_ofs_y == 9'd0))), "result field out of range")

  `MTS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind mosaic_transition_sampler_unit mts_checker u_mts_checker (.*);

`default_nettype wire
